@@ sv/rkc_pkg.sv @@
// shared types, codes and micro-program table of the rk4 coverage integrator
`timescale 1ns / 1ps
package rkc_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_WIDTH = 32;
    localparam int IDX_WIDTH = 3;
    localparam int VAL_WIDTH = 64;
    localparam logic signed [63:0] INT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    localparam int LAST_STEP = 29;
    localparam int LAST_PASS = 3;

    typedef logic [2:0] op_t;
    localparam op_t OP_NOP  = 3'd0;
    localparam op_t OP_ADD  = 3'd1;
    localparam op_t OP_SUB  = 3'd2;
    localparam op_t OP_HALF = 3'd3;
    localparam op_t OP_MUL  = 3'd4;
    localparam op_t OP_DIV6 = 3'd5;
    localparam op_t OP_FIN  = 3'd6;

    typedef logic [1:0] sh_t;
    localparam sh_t SH_RATE  = 2'd0;
    localparam sh_t SH_RATIO = 2'd1;
    localparam sh_t SH_COV   = 2'd2;

    typedef logic [4:0] src_t;
    localparam src_t SR_ZERO = 5'd0;
    localparam src_t SR_ONE  = 5'd1;
    localparam src_t SR_COVF = 5'd2;
    localparam src_t SR_COVS = 5'd3;
    localparam src_t SR_FE   = 5'd4;
    localparam src_t SR_SE   = 5'd5;
    localparam src_t SR_R0   = 5'd6;
    localparam src_t SR_R1   = 5'd7;
    localparam src_t SR_R2   = 5'd8;
    localparam src_t SR_R3   = 5'd9;
    localparam src_t SR_R4   = 5'd10;
    localparam src_t SR_R5   = 5'd11;
    localparam src_t SR_R6   = 5'd12;
    localparam src_t SR_R7   = 5'd13;
    localparam src_t SR_A    = 5'd14;
    localparam src_t SR_B    = 5'd15;
    localparam src_t SR_C    = 5'd16;
    localparam src_t SR_D    = 5'd17;
    localparam src_t SR_E    = 5'd18;
    localparam src_t SR_G    = 5'd19;
    localparam src_t SR_H    = 5'd20;
    localparam src_t SR_I    = 5'd21;
    localparam src_t SR_J    = 5'd22;
    localparam src_t SR_KF   = 5'd23;
    localparam src_t SR_KS   = 5'd24;
    localparam src_t SR_SF   = 5'd25;
    localparam src_t SR_SS   = 5'd26;
    localparam src_t SR_WF   = 5'd27;
    localparam src_t SR_WS   = 5'd28;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        src_t dst;
        sh_t  sh;
    } uop_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        sh_t         sh;
    } mul_req_t;

    function automatic uop_t mk(op_t op, src_t a, src_t b, src_t dst, sh_t sh);
        uop_t u;
        u.op = op;
        u.a = a;
        u.b = b;
        u.dst = dst;
        u.sh = sh;
        return u;
    endfunction

    // one slope evaluation in steps 0..21, per-pass combine in steps 22..29
    function automatic uop_t rkc_uop(logic [1:0] pass, logic [4:0] step);
        uop_t u;
        u = mk(OP_NOP, SR_ZERO, SR_ZERO, SR_ZERO, SH_RATE);
        case (step)
            5'd0:  u = mk(OP_SUB, SR_ONE, SR_FE, SR_A, SH_RATE);
            5'd1:  u = mk(OP_SUB, SR_ONE, SR_SE, SR_B, SH_RATE);
            5'd2:  u = mk(OP_MUL, SR_FE, SR_B, SR_C, SH_COV);
            5'd3:  u = mk(OP_MUL, SR_FE, SR_SE, SR_D, SH_COV);
            5'd4:  u = mk(OP_MUL, SR_FE, SR_FE, SR_E, SH_COV);
            5'd5:  u = mk(OP_MUL, SR_A, SR_R0, SR_A, SH_RATE);
            5'd6:  u = mk(OP_MUL, SR_FE, SR_R1, SR_G, SH_RATE);
            5'd7:  u = mk(OP_MUL, SR_C, SR_R4, SR_C, SH_RATE);
            5'd8:  u = mk(OP_MUL, SR_D, SR_R5, SR_D, SH_RATE);
            5'd9:  u = mk(OP_MUL, SR_C, SR_R7, SR_H, SH_RATIO);
            5'd10: u = mk(OP_MUL, SR_D, SR_R7, SR_I, SH_RATIO);
            5'd11: u = mk(OP_MUL, SR_E, SR_R6, SR_E, SH_RATE);
            5'd12: u = mk(OP_MUL, SR_B, SR_R2, SR_B, SH_RATE);
            5'd13: u = mk(OP_MUL, SR_SE, SR_R3, SR_J, SH_RATE);
            5'd14: u = mk(OP_SUB, SR_A, SR_G, SR_A, SH_RATE);
            5'd15: u = mk(OP_SUB, SR_A, SR_H, SR_A, SH_RATE);
            5'd16: u = mk(OP_SUB, SR_A, SR_I, SR_A, SH_RATE);
            5'd17: u = mk(OP_ADD, SR_E, SR_E, SR_E, SH_RATE);
            5'd18: u = mk(OP_SUB, SR_A, SR_E, SR_KF, SH_RATE);
            5'd19: u = mk(OP_SUB, SR_B, SR_J, SR_B, SH_RATE);
            5'd20: u = mk(OP_ADD, SR_B, SR_C, SR_B, SH_RATE);
            5'd21: u = mk(OP_SUB, SR_B, SR_D, SR_KS, SH_RATE);
            default: begin
                case (pass)
                    2'd0: begin
                        case (step)
                            5'd22: u = mk(OP_HALF, SR_KF, SR_ZERO, SR_G, SH_RATE);
                            5'd23: u = mk(OP_ADD, SR_COVF, SR_G, SR_FE, SH_RATE);
                            5'd24: u = mk(OP_HALF, SR_KS, SR_ZERO, SR_G, SH_RATE);
                            5'd25: u = mk(OP_ADD, SR_COVS, SR_G, SR_SE, SH_RATE);
                            5'd26: u = mk(OP_ADD, SR_KF, SR_ZERO, SR_SF, SH_RATE);
                            5'd27: u = mk(OP_ADD, SR_KS, SR_ZERO, SR_SS, SH_RATE);
                            default: ;
                        endcase
                    end
                    2'd1: begin
                        case (step)
                            5'd22: u = mk(OP_ADD, SR_KF, SR_KF, SR_G, SH_RATE);
                            5'd23: u = mk(OP_ADD, SR_SF, SR_G, SR_SF, SH_RATE);
                            5'd24: u = mk(OP_ADD, SR_KS, SR_KS, SR_G, SH_RATE);
                            5'd25: u = mk(OP_ADD, SR_SS, SR_G, SR_SS, SH_RATE);
                            5'd26: u = mk(OP_HALF, SR_KF, SR_ZERO, SR_G, SH_RATE);
                            5'd27: u = mk(OP_ADD, SR_COVF, SR_G, SR_FE, SH_RATE);
                            5'd28: u = mk(OP_HALF, SR_KS, SR_ZERO, SR_G, SH_RATE);
                            5'd29: u = mk(OP_ADD, SR_COVS, SR_G, SR_SE, SH_RATE);
                            default: ;
                        endcase
                    end
                    2'd2: begin
                        case (step)
                            5'd22: u = mk(OP_ADD, SR_KF, SR_KF, SR_WF, SH_RATE);
                            5'd23: u = mk(OP_ADD, SR_KS, SR_KS, SR_WS, SH_RATE);
                            5'd24: u = mk(OP_ADD, SR_COVF, SR_KF, SR_FE, SH_RATE);
                            5'd25: u = mk(OP_ADD, SR_COVS, SR_KS, SR_SE, SH_RATE);
                            default: ;
                        endcase
                    end
                    default: begin
                        case (step)
                            5'd22: u = mk(OP_ADD, SR_WF, SR_KF, SR_WF, SH_RATE);
                            5'd23: u = mk(OP_ADD, SR_SF, SR_WF, SR_SF, SH_RATE);
                            5'd24: u = mk(OP_ADD, SR_WS, SR_KS, SR_WS, SH_RATE);
                            5'd25: u = mk(OP_ADD, SR_SS, SR_WS, SR_SS, SH_RATE);
                            5'd26: u = mk(OP_DIV6, SR_SF, SR_ZERO, SR_SF, SH_RATE);
                            5'd27: u = mk(OP_DIV6, SR_SS, SR_ZERO, SR_SS, SH_RATE);
                            5'd28: u = mk(OP_FIN, SR_SF, SR_SS, SR_ZERO, SH_RATE);
                            default: ;
                        endcase
                    end
                endcase
            end
        endcase
        return u;
    endfunction

    // saturate a widened sum to the internal range
    function automatic logic signed [63:0] clamp65(logic signed [64:0] x);
        if (x > 65'(INT_LIM)) return INT_LIM;
        if (x < -65'(INT_LIM)) return -INT_LIM;
        return x[63:0];
    endfunction

endpackage

@@ sv/rkc_mul.sv @@
// bit-serial signed fixed-point multiplier with rounding shift and saturation
`timescale 1ns / 1ps
module rkc_mul import rkc_pkg::*; #(
    parameter int FRACTION_BITS = 30
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mul_req_t           req,
    output logic signed [63:0] res,
    output logic               done
);

    logic         run_reg, run_next;
    logic         fin_reg, fin_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [63:0]  hi_reg, hi_next;
    logic [63:0]  lo_reg, lo_next;
    logic [63:0]  ma_reg, ma_next;
    logic         neg_reg, neg_next;
    sh_t          sh_reg, sh_next;
    logic [63:0]  res_reg, res_next;
    logic         done_reg, done_next;

    logic [64:0]  psum;
    logic [127:0] prod;
    logic [127:0] shifted;

    assign psum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, ma_reg} : 65'd0);
    assign prod = {hi_reg, lo_reg};

    always_comb begin
        case (sh_reg)
            SH_RATIO: shifted = (prod + (128'd1 << 23)) >> 24;
            SH_COV:   shifted = (prod + (128'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
            default:  shifted = (prod + (128'd1 << 31)) >> 32;
        endcase
    end

    always_comb begin
        logic [63:0] mag;
        run_next  = run_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        ma_next   = ma_reg;
        neg_next  = neg_reg;
        sh_next   = sh_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        mag = 64'(INT_LIM);
        if (req.start) begin
            ma_next  = req.a[63] ? 64'(-req.a) : req.a;
            lo_next  = req.b[63] ? 64'(-req.b) : req.b;
            hi_next  = '0;
            neg_next = req.a[63] ^ req.b[63];
            sh_next  = req.sh;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            // shift-add one multiplier bit per cycle
            hi_next  = psum[64:1];
            lo_next  = {psum[0], lo_reg[63:1]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end else if (fin_reg) begin
            if (shifted <= 128'(INT_LIM)) mag = shifted[63:0];
            res_next  = neg_reg ? 64'(-mag) : mag;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        ma_reg  <= ma_next;
        neg_reg <= neg_next;
        sh_reg  <= sh_next;
        res_reg <= res_next;
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

@@ sv/rkc_div6.sv @@
// bit-serial divide by six, rounded to nearest with ties away from zero
`timescale 1ns / 1ps
module rkc_div6 import rkc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] x,
    output logic signed [63:0] res,
    output logic               done
);

    logic        run_reg, run_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [2:0]  rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic [63:0] res_reg, res_next;
    logic        done_reg, done_next;

    logic [3:0]  trial;
    logic        qbit;
    logic [63:0] quo;

    assign trial = {rem_reg, num_reg[63]};
    assign qbit  = trial >= 4'd6;
    assign quo   = {num_reg[62:0], qbit};

    always_comb begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        if (start) begin
            num_next = (x[63] ? 64'(-x) : x) + 64'd3;
            rem_next = '0;
            neg_next = x[63];
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            // quotient bits shift in where dividend bits leave
            rem_next = qbit ? 3'(trial - 4'd6) : trial[2:0];
            num_next = quo;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                run_next  = 1'b0;
                res_next  = neg_reg ? 64'(-quo) : quo;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

@@ sv/rk4_surface_coverage_step.sv @@
// top level of the two-site surface coverage rk4 integrator
// Usage:
// Each transaction on the s_ channel is one tick carrying s_restart. On
// acceptance the block loads the current fast and slow coverages and the
// step count (zeros when s_restart is set) into the m_ output register,
// presented on the next cycle, then advances both coverages by one rk4 step.
// The user must write rates on the cfg_ port only while idle (index 0..7,
// 32 bits each); the block itself does not enforce it. No tick is taken
// until the rk4 step in flight is done. The four slope evaluations run
// 12 multiplies each through one bit-serial 64 bit multiplier, plus adds
// and two serial divides by six.
// s_ready is high only when the sequencer is idle and the output register is
// empty or being drained; a stalled m_ channel holds its result and blocks
// the next tick, while the step already in flight still completes.
// Reset clears coverages, count, rate registers and all handshakes.
`timescale 1ns / 1ps
module rk4_surface_coverage_step import rkc_pkg::*; #(
    parameter int FRACTION_BITS = 30,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [IDX_WIDTH-1:0] cfg_index,
    input  logic [REG_WIDTH-1:0] cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_restart,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_theta_f,
    output logic signed [31:0]   m_theta_s,
    output logic [31:0]          m_step_index
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRACTION_BITS;

    logic [1:0] state_reg, state_next;
    logic [1:0] pass_reg;
    logic [4:0] step_reg;

    logic [REG_WIDTH-1:0] rate_reg [NUM_REGS];
    logic signed [31:0] covf_reg, covs_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic signed [63:0] fe_reg, se_reg, a_reg, b_reg, c_reg, d_reg, e_reg;
    logic signed [63:0] g_reg, h_reg, i_reg, j_reg, kf_reg, ks_reg;
    logic signed [63:0] sf_reg, ss_reg, wf_reg, ws_reg;

    logic m_valid_reg;
    logic signed [31:0] out_f_reg, out_s_reg;
    logic [31:0] out_n_reg;

    uop_t uop;
    logic signed [63:0] opa, opb, alu, wdata;
    logic signed [63:0] fin_f, fin_s;
    logic wr_en, advance, accept;
    mul_req_t mreq;
    logic signed [63:0] mul_res, div_res;
    logic mul_done, div_done;

    function automatic logic signed [63:0] pick(src_t c);
        case (c)
            SR_ONE:  return ONE_FX;
            SR_COVF: return 64'(covf_reg);
            SR_COVS: return 64'(covs_reg);
            SR_FE:   return fe_reg;
            SR_SE:   return se_reg;
            SR_R0:   return {32'd0, rate_reg[0]};
            SR_R1:   return {32'd0, rate_reg[1]};
            SR_R2:   return {32'd0, rate_reg[2]};
            SR_R3:   return {32'd0, rate_reg[3]};
            SR_R4:   return {32'd0, rate_reg[4]};
            SR_R5:   return {32'd0, rate_reg[5]};
            SR_R6:   return {32'd0, rate_reg[6]};
            SR_R7:   return {32'd0, rate_reg[7]};
            SR_A:    return a_reg;
            SR_B:    return b_reg;
            SR_C:    return c_reg;
            SR_D:    return d_reg;
            SR_E:    return e_reg;
            SR_G:    return g_reg;
            SR_H:    return h_reg;
            SR_I:    return i_reg;
            SR_J:    return j_reg;
            SR_KF:   return kf_reg;
            SR_KS:   return ks_reg;
            SR_SF:   return sf_reg;
            SR_SS:   return ss_reg;
            SR_WF:   return wf_reg;
            SR_WS:   return ws_reg;
            default: return 64'sd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    assign uop = rkc_uop(pass_reg, step_reg);
    assign opa = pick(uop.a);
    assign opb = pick(uop.b);

    always_comb begin
        logic [63:0] mag;
        mag = opa[63] ? 64'(-opa) : opa;
        mag = (mag + 64'd1) >> 1;
        case (uop.op)
            OP_ADD:  alu = clamp65(65'(opa) + 65'(opb));
            OP_SUB:  alu = clamp65(65'(opa) - 65'(opb));
            OP_HALF: alu = opa[63] ? 64'(-mag) : mag;
            default: alu = 64'sd0;
        endcase
    end

    assign fin_f = clamp65(65'(covf_reg) + 65'(opa));
    assign fin_s = clamp65(65'(covs_reg) + 65'(opb));

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        wr_en   = 1'b0;
        advance = 1'b0;
        wdata   = alu;
        mreq.start = 1'b0;
        mreq.a  = opa;
        mreq.b  = opb;
        mreq.sh = uop.sh;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (uop.op == OP_MUL || uop.op == OP_DIV6) begin
                    mreq.start = (uop.op == OP_MUL);
                    state_next = ST_WAIT;
                end else begin
                    wr_en   = (uop.op == OP_ADD || uop.op == OP_SUB || uop.op == OP_HALF);
                    advance = 1'b1;
                end
            end
            ST_WAIT: begin
                wdata = (uop.op == OP_MUL) ? mul_res : div_res;
                if (mul_done || div_done) begin
                    wr_en      = 1'b1;
                    advance    = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (advance && step_reg == 5'(LAST_STEP) && pass_reg == 2'(LAST_PASS))
            state_next = ST_IDLE;
    end

    rkc_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .res     (mul_res),
        .done    (mul_done)
    );

    rkc_div6 u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_RUN && uop.op == OP_DIV6),
        .x       (opa),
        .res     (div_res),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pass_reg    <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            covf_reg    <= '0;
            covs_reg    <= '0;
            count_reg   <= '0;
            for (int k = 0; k < NUM_REGS; k++) rate_reg[k] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) rate_reg[cfg_index] <= cfg_wdata;
            if (accept) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (accept) begin
                pass_reg <= '0;
                step_reg <= '0;
                if (s_restart) begin
                    covf_reg  <= '0;
                    covs_reg  <= '0;
                    count_reg <= COUNT_WIDTH'(1);
                end else begin
                    count_reg <= count_reg + COUNT_WIDTH'(1);
                end
            end else if (advance) begin
                if (step_reg == 5'(LAST_STEP)) begin
                    step_reg <= '0;
                    pass_reg <= pass_reg + 2'd1;
                end else begin
                    step_reg <= step_reg + 5'd1;
                end
            end
            if (state_reg == ST_RUN && uop.op == OP_FIN) begin
                covf_reg <= sat32(fin_f);
                covs_reg <= sat32(fin_s);
            end
        end
        if (accept) begin
            out_f_reg <= s_restart ? 32'sd0 : covf_reg;
            out_s_reg <= s_restart ? 32'sd0 : covs_reg;
            out_n_reg <= s_restart ? 32'd0 : 32'(count_reg);
            fe_reg    <= s_restart ? 64'sd0 : 64'(covf_reg);
            se_reg    <= s_restart ? 64'sd0 : 64'(covs_reg);
        end else if (wr_en) begin
            case (uop.dst)
                SR_FE: fe_reg <= wdata;
                SR_SE: se_reg <= wdata;
                SR_A:  a_reg  <= wdata;
                SR_B:  b_reg  <= wdata;
                SR_C:  c_reg  <= wdata;
                SR_D:  d_reg  <= wdata;
                SR_E:  e_reg  <= wdata;
                SR_G:  g_reg  <= wdata;
                SR_H:  h_reg  <= wdata;
                SR_I:  i_reg  <= wdata;
                SR_J:  j_reg  <= wdata;
                SR_KF: kf_reg <= wdata;
                SR_KS: ks_reg <= wdata;
                SR_SF: sf_reg <= wdata;
                SR_SS: ss_reg <= wdata;
                SR_WF: wf_reg <= wdata;
                SR_WS: ws_reg <= wdata;
                default: ;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_theta_f    = out_f_reg;
    assign m_theta_s    = out_s_reg;
    assign m_step_index = out_n_reg;

endmodule

@@ sv/rkc_checker.sv @@
// port-level checker for the rk4 coverage integrator and its bind
`timescale 1ns / 1ps
module rkc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_restart,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_theta_f,
    input logic [31:0] m_theta_s,
    input logic [31:0] m_step_index
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // each accepted tick shows its result on the next cycle
    a_result_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("no result after accepted tick");

    // a restart tick reports cleared state
    a_restart_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_restart) |=>
        (m_theta_f == 32'd0 && m_theta_s == 32'd0 && m_step_index == 32'd0))
        else $error("restart tick not cleared");

    // a stalled result blocks new ticks
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("tick accepted over stalled result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_theta_f) && $stable(m_step_index)))
        else $error("stalled result changed");

endmodule

bind rk4_surface_coverage_step rkc_checker u_rkc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_restart    (s_restart),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_theta_f    (m_theta_f),
    .m_theta_s    (m_theta_s),
    .m_step_index (m_step_index)
);

@@ verif/tb.sv @@
// self-checking testbench of the rk4 surface coverage integrator
`timescale 1ns / 1ps
module tb;
    import rkc_pkg::*;

    localparam longint LIM      = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam int     FRAC     = 30;
    localparam int     SETTLE   = 4500;
    localparam longint MAX_CYC  = 20_000_000;

    typedef struct {
        logic signed [31:0] theta_f;
        logic signed [31:0] theta_s;
        logic [31:0]        step_index;
    } coverage_out_t;

    class rk4_tracker;
        logic [31:0]        rate [NUM_REGS];
        logic signed [31:0] cov_f;
        logic signed [31:0] cov_s;
        logic [31:0]        steps;
        coverage_out_t      pending [$];
        int                 errors;
        int                 checked;

        function new();
            foreach (rate[i]) rate[i] = '0;
            cov_f = 0;
            cov_s = 0;
            steps = 0;
            errors = 0;
            checked = 0;
        endfunction

        function longint clip(longint x);
            if (x > LIM) return LIM;
            if (x < -LIM) return -LIM;
            return x;
        endfunction

        function longint sum(longint a, longint b);
            return clip(a + b);
        endfunction

        // rounded, saturated product scaled down by 2^sh
        function longint mulr(longint a, longint b, int sh);
            logic [63:0]  ma, mb;
            logic [127:0] p;
            longint       r;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            p = {64'b0, ma} * {64'b0, mb};
            p = p + (128'd1 << (sh - 1));
            p = p >> sh;
            r = (p > 128'(LIM)) ? LIM : longint'(p[63:0]);
            return ((a < 0) != (b < 0)) ? -r : r;
        endfunction

        function longint r(int i);
            return longint'({32'b0, rate[i]});
        endfunction

        function void slope(longint f, longint s, output longint kf, output longint ks);
            longint one_f, one_s, fs_free, fs_occ, ff, t1, t2, t3, t4, t5, t6, t5r, t6r, t7;
            one_f = sum(longint'(1) << FRAC, -f);
            one_s = sum(longint'(1) << FRAC, -s);
            fs_free = mulr(f, one_s, FRAC);
            fs_occ = mulr(f, s, FRAC);
            ff = mulr(f, f, FRAC);
            t1 = mulr(one_f, r(0), 32);
            t2 = mulr(f, r(1), 32);
            t5 = mulr(fs_free, r(4), 32);
            t6 = mulr(fs_occ, r(5), 32);
            t5r = mulr(t5, r(7), 24);
            t6r = mulr(t6, r(7), 24);
            t7 = mulr(ff, r(6), 32);
            t3 = mulr(one_s, r(2), 32);
            t4 = mulr(s, r(3), 32);
            kf = sum(sum(sum(sum(t1, -t2), -t5r), -t6r), -sum(t7, t7));
            ks = sum(sum(sum(t3, -t4), t5), -t6);
        endfunction

        function longint div6(longint x);
            longint m;
            m = (x < 0) ? -x : x;
            m = (m + 3) / 6;
            return (x < 0) ? -m : m;
        endfunction

        function logic signed [31:0] to32(longint x);
            if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (x < -64'sd2147483648) return 32'sh8000_0000;
            return x[31:0];
        endfunction

        function void note_tick(bit restart);
            coverage_out_t e;
            longint f, s, kf1, ks1, kf2, ks2, kf3, ks3, kf4, ks4, sf, ss;
            if (restart) begin
                cov_f = 0;
                cov_s = 0;
                steps = 0;
            end
            f = cov_f;
            s = cov_s;
            e.theta_f = cov_f;
            e.theta_s = cov_s;
            e.step_index = steps;
            pending.push_back(e);
            slope(f, s, kf1, ks1);
            slope(sum(f, mulr(kf1, 1, 1)), sum(s, mulr(ks1, 1, 1)), kf2, ks2);
            slope(sum(f, mulr(kf2, 1, 1)), sum(s, mulr(ks2, 1, 1)), kf3, ks3);
            slope(sum(f, kf3), sum(s, ks3), kf4, ks4);
            sf = sum(sum(kf1, sum(kf2, kf2)), sum(sum(kf3, kf3), kf4));
            ss = sum(sum(ks1, sum(ks2, ks2)), sum(sum(ks3, ks3), ks4));
            cov_f = to32(sum(f, div6(sf)));
            cov_s = to32(sum(s, div6(ss)));
            steps = steps + 1;
        endfunction

        function void check_result(logic signed [31:0] f, logic signed [31:0] s,
                                   logic [31:0] n);
            coverage_out_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result f=%h s=%h n=%0d", $realtime, f, s, n);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (f !== e.theta_f) begin
                $display("%0t: theta_f expected %h actual %h", $realtime, e.theta_f, f);
                errors++;
            end
            if (s !== e.theta_s) begin
                $display("%0t: theta_s expected %h actual %h", $realtime, e.theta_s, s);
                errors++;
            end
            if (n !== e.step_index) begin
                $display("%0t: step_index expected %0d actual %0d", $realtime,
                         e.step_index, n);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_we = 0;
    logic [IDX_WIDTH-1:0] cfg_index = '0;
    logic [REG_WIDTH-1:0] cfg_wdata = '0;
    logic                 s_valid = 0;
    logic                 s_ready;
    logic                 s_restart = 0;
    logic                 m_valid;
    logic                 m_ready = 1;
    logic signed [31:0]   m_theta_f;
    logic signed [31:0]   m_theta_s;
    logic [31:0]          m_step_index;

    rk4_tracker tracker = new();
    int         send_gap_pct = 0;
    int         stall_pct = 0;
    int         ticks_sent = 0;
    int         restarts_sent = 0;
    longint     cycles = 0;

    rk4_surface_coverage_step dut (.*);

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        if (aresetn)
            m_ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_theta_f, m_theta_s, m_step_index);
        if (cycles > MAX_CYC) begin
            $display("%0t: timeout, %0d results outstanding", $realtime,
                     tracker.pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_rate(int idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we = 1;
        cfg_index = IDX_WIDTH'(idx);
        cfg_wdata = val;
        tracker.rate[idx] = val;
        @(negedge aclk);
        cfg_we = 0;
    endtask

    // only touch the rates once the block has drained its step in flight
    task automatic wait_idle();
        while (tracker.pending.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic send_tick(bit restart);
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) @(negedge aclk);
        s_valid = 1;
        s_restart = restart;
        do @(posedge aclk); while (!s_ready);
        tracker.note_tick(restart);
        ticks_sent++;
        if (restart) restarts_sent++;
        @(negedge aclk);
        s_valid = 0;
        s_restart = 1'($urandom_range(1));
    endtask

    // rate mixes: 0 all zero, 1 all ones, 2 physically plausible, 3 anything
    task automatic load_rates(int mix);
        logic [31:0] v;
        for (int i = 0; i < NUM_REGS; i++) begin
            case (mix)
                0: v = '0;
                1: v = '1;
                2: v = (i == 7) ? $urandom_range(32'h0200_0000, 32'h0040_0000)
                                : $urandom_range(32'h0400_0000, 0);
                default: begin
                    case ($urandom_range(3))
                        0: v = '0;
                        1: v = '1;
                        default: v = $urandom;
                    endcase
                end
            endcase
            write_rate(i, v);
        end
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1;

        // directed: zero rates, full-scale rates, then plausible ones
        send_tick(0);
        send_tick(0);
        wait_idle();
        load_rates(1);
        repeat (6) send_tick(0);
        send_tick(1);
        repeat (3) send_tick(0);
        wait_idle();
        load_rates(2);
        repeat (8) send_tick(0);
        send_tick(1);
        send_tick(0);

        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            load_rates((ph % 3 == 2) ? 3 : 2);
            send_gap_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 74 : 7) : 0;
            stall_pct = (ph % 4 == 2) ? 74 : ((ph % 4 == 3) ? 7 : 0);
            send_tick(1);
            for (int k = 0; k < 65; k++)
                send_tick($urandom_range(99) < 4);
        end
        send_gap_pct = 0;
        stall_pct = 0;

        while (tracker.pending.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        $display("ran %0d ticks (%0d with restart), checked %0d results", ticks_sent,
                 restarts_sent, tracker.checked);
        $display("rate sets covered zero, full scale, plausible and random values");
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
